// File: rtl/time_optimal_speed_step_unit_macros.svh
// Assertion macros for the speed step unit checker.
// No dependencies; included by the checker file only.
`ifndef TIME_OPTIMAL_SPEED_STEP_UNIT_MACROS_SVH
`define TIME_OPTIMAL_SPEED_STEP_UNIT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define TOSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define TOSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/toss_pkg.sv
// Shared widths, register codes and the configuration struct of the speed step unit.
// No dependencies.
package toss_pkg;

   localparam int DIST_W     = 24;
   localparam int SPEED_W    = 16;
   localparam int MAG_W      = 15;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int LHS_W      = DIST_W + LIMIT_W + 2;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int NUM_STAGES = 5;

   localparam logic [MAG_W-1:0] SPEED_SAT = {MAG_W{1'b1}};

   localparam logic [LIMIT_W-1:0] ACCEL_RESET  = 16'd4000;
   localparam logic [LIMIT_W-1:0] DECEL_RESET  = 16'd4000;
   localparam logic [MAG_W-1:0]   SPEED_RESET  = 15'd1000;
   localparam logic [LIMIT_W-1:0] PERIOD_RESET = 16'd3277;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL  = 2'd0,
      CSR_DECEL  = 2'd1,
      CSR_SPEED  = 2'd2,
      CSR_PERIOD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] decel;
      logic [MAG_W-1:0]   speed_limit;
      logic [LIMIT_W-1:0] dv;
      logic [LIMIT_W-1:0] dd;
   } toss_cfg_type;

endpackage

// File: rtl/time_optimal_speed_step_unit.sv
// Top level of the speed step unit: configuration registers and the datapath.
// Depends on toss_pkg, toss_csr and toss_pipe.
//
// One control step per beat: a request is taken on any cycle with start high
// and busy low (busy is high only during reset), and its commanded speed appears
// on rsp_speed_next with rsp_valid high, one cycle wide, after it has passed
// the five register stages (input magnitude, distance-times-deceleration
// multiply, speed squares, stopping-distance compare, decision); a new request
// may follow on every cycle. The receiver cannot stall:
// take each response in the cycle it is shown. Write configuration only when no
// response is pending; csr_ready is always high.
module time_optimal_speed_step_unit
   import toss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [DIST_W-1:0]  req_distance_left,
   input  logic signed [SPEED_W-1:0] req_speed_now,
   input  logic                      req_backward,
   output logic                      rsp_valid,
   output logic signed [SPEED_W-1:0] rsp_speed_next,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   toss_cfg_type cfg;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   toss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   toss_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ~busy),
      .in_distance (req_distance_left),
      .in_speed    (req_speed_now),
      .in_backward (req_backward),
      .cfg         (cfg),
      .out_valid   (rsp_valid),
      .out_speed   (rsp_speed_next)
   );

endmodule

// File: rtl/toss_csr.sv
// Configuration registers and the per-step speed increments derived from them.
// Depends on toss_pkg.
module toss_csr
   import toss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output toss_cfg_type          cfg
);

   logic [LIMIT_W-1:0]   accel_ff, decel_ff, period_ff;
   logic [MAG_W-1:0]     speed_ff;
   logic [LIMIT_W-1:0]   dv_ff, dd_ff, dv_in, dd_in;
   logic [2*LIMIT_W-1:0] dv_prod, dd_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= ACCEL_RESET;
         decel_ff  <= DECEL_RESET;
         speed_ff  <= SPEED_RESET;
         period_ff <= PERIOD_RESET;
      end else if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_ACCEL:  accel_ff  <= wr_data;
            CSR_DECEL:  decel_ff  <= wr_data;
            CSR_SPEED:  speed_ff  <= wr_data[MAG_W-1:0];
            CSR_PERIOD: period_ff <= wr_data;
            default:    accel_ff  <= accel_ff;
         endcase
      end
   end

   // Increments per step, floor of limit*period/65536
   always_comb begin
      dv_prod = accel_ff * period_ff;
      dd_prod = decel_ff * period_ff;
      dv_in   = dv_prod[2*LIMIT_W-1:LIMIT_W];
      dd_in   = dd_prod[2*LIMIT_W-1:LIMIT_W];
   end

   always_ff @(posedge clock) begin
      dv_ff <= dv_in;
      dd_ff <= dd_in;
   end

   assign cfg.decel       = decel_ff;
   assign cfg.speed_limit = speed_ff;
   assign cfg.dv          = dv_ff;
   assign cfg.dd          = dd_ff;

endmodule

// File: rtl/toss_pipe.sv
// Five-stage datapath: magnitude, stopping-distance product, squares, compare, decision.
// Depends on toss_pkg.
module toss_pipe
   import toss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [DIST_W-1:0]  in_distance,
   input  logic signed [SPEED_W-1:0] in_speed,
   input  logic                      in_backward,
   input  toss_cfg_type              cfg,
   output logic                      out_valid,
   output logic signed [SPEED_W-1:0] out_speed
);

   logic [NUM_STAGES-1:0] valid_ff;

   // stage 1
   logic signed [DIST_W-1:0] s1_dist_ff;
   logic [MAG_W-1:0]         s1_v_ff, s1_v_in;
   logic                     s1_rev_ff;
   logic [SPEED_W-1:0]       mag;
   // stage 2
   logic signed [LHS_W-1:0]  s2_lhs_ff, s2_lhs_in;
   logic [MAG_W-1:0]         s2_v_ff, s2_vp_ff, s2_vp_in;
   logic                     s2_rev_ff;
   logic [MAG_W+1:0]         vsum;
   // stage 3
   logic signed [LHS_W-1:0]  s3_lhs_ff;
   logic [SQ_W-1:0]          s3_sqv_ff, s3_sqp_ff;
   logic [MAG_W-1:0]         s3_v_ff, s3_vp_ff;
   logic                     s3_rev_ff;
   // stage 4
   logic                     s4_safe_v_ff, s4_safe_p_ff;
   logic [MAG_W-1:0]         s4_v_ff, s4_vp_ff;
   logic                     s4_rev_ff;
   // stage 5
   logic signed [SPEED_W-1:0] s5_speed_ff, s5_speed_in;
   logic [MAG_W-1:0]          res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], in_valid};
      end
   end

   // Magnitude; the most negative speed saturates
   always_comb begin
      mag     = in_speed[SPEED_W-1] ? (~in_speed + 1'b1) : in_speed;
      s1_v_in = mag[SPEED_W-1] ? SPEED_SAT : mag[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      s1_dist_ff <= in_distance;
      s1_v_ff    <= s1_v_in;
      s1_rev_ff  <= in_backward;
   end

   // dist*2*decel and saturated v+dv
   always_comb begin
      s2_lhs_in = LHS_W'(s1_dist_ff * $signed({1'b0, cfg.decel})) <<< 1;
      vsum      = {2'b00, s1_v_ff} + {1'b0, cfg.dv};
      s2_vp_in  = (vsum > {2'b00, SPEED_SAT}) ? SPEED_SAT : vsum[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      s2_lhs_ff <= s2_lhs_in;
      s2_v_ff   <= s1_v_ff;
      s2_vp_ff  <= s2_vp_in;
      s2_rev_ff <= s1_rev_ff;
   end

   always_ff @(posedge clock) begin
      s3_lhs_ff <= s2_lhs_ff;
      s3_sqv_ff <= s2_v_ff * s2_v_ff;
      s3_sqp_ff <= s2_vp_ff * s2_vp_ff;
      s3_v_ff   <= s2_v_ff;
      s3_vp_ff  <= s2_vp_ff;
      s3_rev_ff <= s2_rev_ff;
   end

   always_ff @(posedge clock) begin
      s4_safe_v_ff <= s3_lhs_ff > $signed({{(LHS_W-SQ_W){1'b0}}, s3_sqv_ff});
      s4_safe_p_ff <= s3_lhs_ff > $signed({{(LHS_W-SQ_W){1'b0}}, s3_sqp_ff});
      s4_v_ff      <= s3_v_ff;
      s4_vp_ff     <= s3_vp_ff;
      s4_rev_ff    <= s3_rev_ff;
   end

   // Accelerate, cruise or brake, in that order
   always_comb begin
      priority if (s4_safe_p_ff && (s4_v_ff < cfg.speed_limit)) begin
         res = (s4_vp_ff < cfg.speed_limit) ? s4_vp_ff : cfg.speed_limit;
      end else if (s4_safe_v_ff && (s4_v_ff == cfg.speed_limit)) begin
         res = s4_v_ff;
      end else if ({1'b0, s4_v_ff} > cfg.dd) begin
         res = s4_v_ff - cfg.dd[MAG_W-1:0];
      end else begin
         res = '0;
      end
      s5_speed_in = s4_rev_ff ? -$signed({1'b0, res}) : $signed({1'b0, res});
   end

   always_ff @(posedge clock) begin
      s5_speed_ff <= s5_speed_in;
   end

   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_speed = s5_speed_ff;

endmodule

// File: rtl/toss_checker.sv
// Port-level checks of the speed step unit, bound to the top level.
// Depends on toss_pkg and time_optimal_speed_step_unit_macros.svh.
`include "time_optimal_speed_step_unit_macros.svh"

module toss_checker
   import toss_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic signed [DIST_W-1:0]  req_distance_left,
   input logic signed [SPEED_W-1:0] req_speed_now,
   input logic                      req_backward,
   input logic                      rsp_valid,
   input logic signed [SPEED_W-1:0] rsp_speed_next
);

   `TOSS_ASSERT(a_rsp_follows_req, clock, reset, start && !busy |-> ##5 rsp_valid, "request beat without response after five cycles")
   `TOSS_ASSERT(a_no_spurious_rsp, clock, reset, rsp_valid |-> $past(start && !busy, 5), "response beat without a request five cycles earlier")
   `TOSS_ASSERT(a_forward_sign, clock, reset, rsp_valid && $past(start && !busy && !req_backward, 5) |-> !rsp_speed_next[SPEED_W-1], "forward request gave a negative speed")
   `TOSS_ASSERT(a_no_goal_stop, clock, reset, rsp_valid && $past(req_distance_left[DIST_W-1] && (req_speed_now == '0), 5) |-> (rsp_speed_next == '0), "standing start behind the goal did not stay at rest")

endmodule

bind time_optimal_speed_step_unit toss_checker u_toss_checker (.*);
